// ===== rtl/lebuf_pkg.sv =====
// Shared types, character codes and message text for the console line buffer.
package lebuf_pkg;

  // Default total message buffer size in bytes.
  localparam int BUF_BYTES_DEF = 64;

  // Fixed parts of the echoed message.
  localparam int PREFIX_LEN = 14;
  localparam int SUFFIX_LEN = 3;

  // Character codes that steer the editor.
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  // Kinds of command that the front hands to the back.
  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_ERASE,
    CMD_ENTER
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
  } cmd_t;

  // Text of the message prefix: You entered: "
  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h59;  // Y
      4'd1:    ch = 8'h6F;  // o
      4'd2:    ch = 8'h75;  // u
      4'd3:    ch = 8'h20;  // space
      4'd4:    ch = 8'h65;  // e
      4'd5:    ch = 8'h6E;  // n
      4'd6:    ch = 8'h74;  // t
      4'd7:    ch = 8'h65;  // e
      4'd8:    ch = 8'h72;  // r
      4'd9:    ch = 8'h65;  // e
      4'd10:   ch = 8'h64;  // d
      4'd11:   ch = 8'h3A;  // colon
      4'd12:   ch = 8'h20;  // space
      4'd13:   ch = CHAR_QUOTE;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Text of the message suffix: closing quote, CR, LF.
  function automatic logic [7:0] suffix_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CHAR_QUOTE;
      2'd1:    ch = CHAR_CR;
      2'd2:    ch = CHAR_LF;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/line_edit_echo_buffer.sv =====
// Top level: console line editor that echoes the line on Enter.
// A byte is taken while the two-entry command queue has room.
// Editing commands take effect when the idle line engine takes them from the queue; on Enter
// the message follows: prefix and suffix bytes come one per cycle while the receiver does not
// stall, and each stored character is read from the registered line store before it is sent.
// Reset clears the character count and all control state; the line store is not cleared.
module line_edit_echo_buffer #(
  parameter int BUF_BYTES = lebuf_pkg::BUF_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       end_of_message_o
);
  import lebuf_pkg::*;

  logic push, full, pop, cmd_valid;
  cmd_t push_cmd, pop_cmd;

  // Classification of received bytes.
  lebuf_front u_front (
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Queue that decouples input from message output.
  lebuf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (pop_cmd)
  );

  // Line editing and message streaming.
  lebuf_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (pop_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .end_of_message_o (end_of_message_o)
  );

endmodule

// ===== rtl/lebuf_front.sv =====
// Front end: takes received bytes and turns the meaningful ones into commands.
module lebuf_front (
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  output logic              in_stall_o,
  input  logic              full_i,
  output logic              push_o,
  output lebuf_pkg::cmd_t   cmd_o
);
  import lebuf_pkg::*;

  logic keep;

  // Classify the byte; control codes other than erase and Enter, and bytes above 7Fh, are dropped.
  always_comb begin
    keep       = 1'b1;
    cmd_o.kind = CMD_APPEND;
    cmd_o.data = in_byte_i;
    if (in_byte_i inside {[CHAR_SPACE:CHAR_TILDE]}) begin
      cmd_o.kind = CMD_APPEND;
    end else if (in_byte_i inside {CHAR_BS, CHAR_DEL}) begin
      cmd_o.kind = CMD_ERASE;
    end else if (in_byte_i inside {CHAR_CR, CHAR_LF}) begin
      cmd_o.kind = CMD_ENTER;
    end else begin
      keep = 1'b0;
    end
  end

  // Ignored bytes are taken as well, they just never reach the queue.
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i & keep;

endmodule

// ===== rtl/lebuf_cmd_fifo.sv =====
// Two-entry command queue between the front end and the line engine.
module lebuf_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lebuf_pkg::cmd_t   cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lebuf_pkg::cmd_t   cmd_o
);
  import lebuf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/lebuf_back.sv =====
// Line engine: edits the stored line and streams the echoed message.
module lebuf_back #(
  parameter int BUF_BYTES = lebuf_pkg::BUF_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  lebuf_pkg::cmd_t   cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_byte_o,
  output logic              end_of_message_o
);
  import lebuf_pkg::*;

  localparam int LineCap = BUF_BYTES - PREFIX_LEN - SUFFIX_LEN - 1;
  localparam int AddrW   = (LineCap > 1) ? $clog2(LineCap) : 1;
  localparam int CntW    = $clog2(LineCap + 1);
  localparam int IdxMax  = (LineCap > PREFIX_LEN) ? LineCap : PREFIX_LEN;
  localparam int IdxW    = $clog2(IdxMax + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREFIX,
    S_LREAD,
    S_LEMIT,
    S_SUFFIX
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic            eom_q;

  logic [7:0]      mem [LineCap];
  logic [7:0]      rdata_q;
  logic            mem_we, mem_re;
  logic            slot_free;
  logic            out_load;
  logic            line_last;

  assign pop_o            = (state_q == S_IDLE) & cmd_valid_i;
  assign slot_free        = ~out_valid_q | ~out_stall_i;
  assign out_load         = slot_free & (state_q inside {S_PREFIX, S_LEMIT, S_SUFFIX});
  assign line_last        = ((idx_q + IdxW'(1)) == IdxW'(count_q));
  assign mem_we           = pop_o & (cmd_i.kind == CMD_APPEND) & (count_q < CntW'(LineCap));
  assign mem_re           = (state_q == S_LREAD);
  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign end_of_message_o = eom_q;

  // Line store: written on append, read one character at a time on echo.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AddrW-1:0]] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= mem[idx_q[AddrW-1:0]];
    end
  end

  // Sequencer: editing commands, then prefix, line and suffix of a message.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      eom_q       <= 1'b0;
    end else begin
      // The output register fills on each message byte and empties once its
      // transfer completes.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              CMD_APPEND: begin
                if (count_q < CntW'(LineCap)) begin
                  count_q <= count_q + CntW'(1);
                end
              end
              CMD_ERASE: begin
                if (count_q != '0) begin
                  count_q <= count_q - CntW'(1);
                end
              end
              CMD_ENTER: begin
                idx_q   <= '0;
                state_q <= S_PREFIX;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_PREFIX: begin
          if (slot_free) begin
            out_byte_q  <= prefix_char(idx_q[3:0]);
            eom_q       <= 1'b0;
            if (idx_q == IdxW'(PREFIX_LEN - 1)) begin
              idx_q   <= '0;
              state_q <= (count_q == '0) ? S_SUFFIX : S_LREAD;
            end else begin
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        S_LREAD: begin
          state_q <= S_LEMIT;
        end
        S_LEMIT: begin
          if (slot_free) begin
            out_byte_q  <= rdata_q;
            eom_q       <= 1'b0;
            if (line_last) begin
              idx_q   <= '0;
              state_q <= S_SUFFIX;
            end else begin
              idx_q   <= idx_q + IdxW'(1);
              state_q <= S_LREAD;
            end
          end
        end
        S_SUFFIX: begin
          if (slot_free) begin
            out_byte_q  <= suffix_char(idx_q[1:0]);
            if (idx_q == IdxW'(SUFFIX_LEN - 1)) begin
              eom_q   <= 1'b1;
              count_q <= '0;
              idx_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              eom_q <= 1'b0;
              idx_q <= idx_q + IdxW'(1);
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sim/line_edit_echo_buffer_tb.sv =====
// Self-checking testbench for the console line editor that echoes its line on Enter.
`timescale 1ns / 1ps

module line_edit_echo_buffer_tb;
  import lebuf_pkg::*;

  // The line holds the buffer less prefix, suffix and one spare byte.
  localparam int LINE_CAP     = BUF_BYTES_DEF - PREFIX_LEN - SUFFIX_LEN - 1;
  localparam int RANDOM_KEYS  = 140;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOW_LIMIT   = 10;

  localparam string LEAD_TEXT = "You entered: \"";
  localparam string TAIL_TEXT = "\"\r\n";
  localparam string BARE_MSG  = "You entered: \"\"\r\n";

  // One byte of an echoed message.
  typedef struct packed {
    logic [7:0] ch;
    logic       eom;
  } echo_byte_t;

  // How a directed row is checked: no output at all, the bare message, or the line model.
  typedef enum logic [1:0] {
    ROW_SILENT,
    ROW_BARE,
    ROW_PREDICT
  } row_check_e;

  typedef struct packed {
    logic [7:0] ch;
    row_check_e check;
  } key_row_t;

  // Directed keys: empty-line Enter, erase on empty, ignored bytes, edits, reuse of
  // an erased entry.
  key_row_t key_table [24] = '{
    '{CHAR_CR,    ROW_BARE},
    '{CHAR_LF,    ROW_BARE},
    '{CHAR_DEL,   ROW_SILENT},
    '{CHAR_BS,    ROW_SILENT},
    '{8'h00,      ROW_SILENT},
    '{8'hFF,      ROW_SILENT},
    '{8'h80,      ROW_SILENT},
    '{8'h1F,      ROW_SILENT},
    '{CHAR_SPACE, ROW_SILENT},
    '{CHAR_TILDE, ROW_SILENT},
    '{CHAR_CR,    ROW_PREDICT},
    '{8'h41,      ROW_SILENT},
    '{8'h5A,      ROW_SILENT},
    '{CHAR_BS,    ROW_SILENT},
    '{8'h7A,      ROW_SILENT},
    '{CHAR_DEL,   ROW_SILENT},
    '{CHAR_DEL,   ROW_SILENT},
    '{8'h21,      ROW_SILENT},
    '{CHAR_LF,    ROW_PREDICT},
    '{8'h0B,      ROW_SILENT},
    '{8'h09,      ROW_SILENT},
    '{8'h1B,      ROW_SILENT},
    '{8'h0E,      ROW_SILENT},
    '{CHAR_LF,    ROW_BARE}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       end_of_message_o;

  // Line model state and the bytes still owed by the block.
  logic [7:0]  line_chars [LINE_CAP];
  int unsigned line_len   = 0;
  echo_byte_t  echo_q [$];
  int unsigned fail_count = 0;
  int unsigned key_count  = 0;

  // Traffic shaping shared by sender and receiver.
  logic        calm       = 1'b0;
  int unsigned hold_token = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  line_edit_echo_buffer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_byte_i        (in_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .end_of_message_o (end_of_message_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Bytes that edit the line or end it; everything else is dropped by the block.
  function automatic bit is_effective(input logic [7:0] key);
    return (key >= CHAR_SPACE && key <= CHAR_DEL) || key == CHAR_BS ||
           key == CHAR_CR || key == CHAR_LF;
  endfunction

  // A control byte or a high byte that the editor ignores.
  function automatic logic [7:0] noise_key();
    logic [7:0] k;
    if ($urandom_range(1) != 0) begin
      k = 8'($urandom_range(8'h80, 8'hFF));
    end else begin
      k = 8'($urandom_range(8'h00, 8'h1F));
      if (k == CHAR_BS || k == CHAR_LF || k == CHAR_CR) k = 8'h1B;
    end
    return k;
  endfunction

  // Queue the bytes of a text, flagging its last byte when it closes a message.
  function automatic void queue_text(input string s, input bit closes);
    echo_byte_t b;
    for (int i = 0; i < s.len(); i++) begin
      b.ch  = s[i];
      b.eom = closes && (i == s.len() - 1);
      echo_q.push_back(b);
    end
  endfunction

  // Line editor model: apply one key, and on Enter optionally queue the echo.
  function automatic void apply_key(input logic [7:0] key, input bit emit);
    echo_byte_t b;
    if (key >= CHAR_SPACE && key <= CHAR_TILDE) begin
      if (line_len < LINE_CAP) begin
        line_chars[line_len] = key;
        line_len++;
      end
    end else if (key == CHAR_BS || key == CHAR_DEL) begin
      if (line_len != 0) line_len--;
    end else if (key == CHAR_CR || key == CHAR_LF) begin
      if (emit) begin
        queue_text(LEAD_TEXT, 1'b0);
        for (int i = 0; i < line_len; i++) begin
          b.ch  = line_chars[i];
          b.eom = 1'b0;
          echo_q.push_back(b);
        end
        queue_text(TAIL_TEXT, 1'b1);
      end
      line_len = 0;
    end
  endfunction

  // Offer one key, with random gaps, and update the model once the transfer happens.
  task automatic send_key(input logic [7:0] key, input row_check_e check);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= key;
    do @(posedge clk_i); while (in_stall_o);
    apply_key(key, check == ROW_PREDICT);
    if (check == ROW_BARE) queue_text(BARE_MSG, 1'b1);
    if (is_effective(key)) key_count++;
  endtask

  // Receiver stall: random, off while calm, and a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen   <= hold_token;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 24);
    end
  end

  // Compare each output transfer with the oldest owed byte.
  always @(posedge clk_i) begin
    echo_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (echo_q.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected output byte %02h eom %0b", out_byte_o, end_of_message_o);
      end else begin
        want = echo_q.pop_front();
        if (out_byte_o !== want.ch || end_of_message_o !== want.eom) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("echo mismatch: expected byte %02h eom %0b, got byte %02h eom %0b",
                     want.ch, want.eom, out_byte_o, end_of_message_o);
        end
      end
    end
  end

  // Stimulus: reset, directed keys, a drain pause, then random lines.
  initial begin
    int unsigned line_goal;
    int unsigned roll;
    int unsigned erase_pct;
    int          seq_idx;
    logic [7:0]  key;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (key_table[r]) send_key(key_table[r].ch, key_table[r].check);

    // Sender waits until every owed byte has come out.
    in_valid_i <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);

    // Random lines: mostly short, one overfilled, some long, some erase-heavy.
    key_count = 0;
    seq_idx   = 0;
    while (key_count < RANDOM_KEYS) begin
      calm <= (seq_idx == 4 || seq_idx == 5);
      // Hold the receiver off right behind the overfilled line's echo.
      if (seq_idx == 2) hold_token <= hold_token + 1;
      if (seq_idx == 1) line_goal = $urandom_range(LINE_CAP + 1, LINE_CAP + 8);
      else if ($urandom_range(4) == 0) line_goal = $urandom_range(20, LINE_CAP + 4);
      else line_goal = $urandom_range(0, 10);
      if (seq_idx == 1) erase_pct = 0;
      else erase_pct = ($urandom_range(5) == 0) ? 45 : 8;
      for (int k = 0; k < line_goal; k++) begin
        roll = $urandom_range(99);
        if (roll < erase_pct) key = ($urandom_range(1) != 0) ? CHAR_BS : CHAR_DEL;
        else if (roll < erase_pct + 6) key = noise_key();
        else key = 8'($urandom_range(CHAR_SPACE, CHAR_TILDE));
        send_key(key, ROW_PREDICT);
      end
      send_key(($urandom_range(1) != 0) ? CHAR_CR : CHAR_LF, ROW_PREDICT);
      seq_idx++;
    end

    // Let the last message drain, then watch for stray bytes.
    in_valid_i <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && echo_q.size() == 0) begin
      $display("line_edit_echo_buffer_tb: done, clean");
    end else begin
      $display("line_edit_echo_buffer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: reports errors and stops a run that does not finish.
  initial begin
    #2_000_000;
    $display("line_edit_echo_buffer_tb: done, errors");
    $finish;
  end

endmodule
